// File: hdl/lidar_point_to_pixel_projection_core_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef LIDAR_POINT_TO_PIXEL_PROJECTION_CORE_MACROS_SVH
`define LIDAR_POINT_TO_PIXEL_PROJECTION_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define LPPP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LPPP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPPP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LPPP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/lppp_pkg.sv
`default_nettype none
package lppp_pkg;

  // Quotient bits resolved by the divider; larger quotients fall outside any image.
  localparam int QBITS = 40;
  localparam int NBITS = 44;
  localparam int CFG_IDX_W = 3;
  // multiply, prepare, divide steps, offset add
  localparam int PROJ_LAT = QBITS + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW0  = 3'd0,
    CFG_ROW1  = 3'd1,
    CFG_ROW2  = 3'd2,
    CFG_FOCAL = 3'd3,
    CFG_PP    = 3'd4,
    CFG_DIMS  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                    ok;
    logic                    rnz;
    logic signed [NBITS-1:0] n;
  } proj_res_t;

endpackage
`default_nettype wire

// File: hdl/lppp_xform.sv
`default_nettype none
module lppp_xform (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] px,
  input  wire logic signed [31:0] py,
  input  wire logic signed [31:0] pz,
  input  wire logic        [63:0] row0,
  input  wire logic        [63:0] row1,
  input  wire logic        [63:0] row2,
  output logic                    out_valid,
  output logic signed [31:0]      cam_x,
  output logic signed [31:0]      cam_y,
  output logic signed [31:0]      cam_z
);

  logic [63:0]        rows [3];
  logic signed [31:0] pt   [3];

  logic signed [47:0] prod_r   [3][3];
  logic signed [47:0] prod_nxt [3][3];
  logic signed [49:0] sum_r    [3];
  logic signed [49:0] sum_nxt  [3];
  logic signed [31:0] cam_r    [3];
  logic signed [31:0] cam_nxt  [3];
  logic [2:0]         v_r;

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;
  assign pt[0]   = px;
  assign pt[1]   = py;
  assign pt[2]   = pz;

  always_comb begin
    logic signed [47:0] a48;
    logic signed [47:0] b48;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        a48 = 48'($signed(rows[r][16*k +: 16]));
        b48 = 48'(pt[k]);
        prod_nxt[r][k] = a48 * b48;
      end
    end
  end

  // Fold the translation and the rounding bias into the sum.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = 50'(prod_r[r][0]) + 50'(prod_r[r][1]) + 50'(prod_r[r][2])
                 + (50'($signed(rows[r][63:48])) <<< 20) + 50'sd8192;
    end
  end

  always_comb begin
    logic signed [49:0] sh;
    for (int r = 0; r < 3; r++) begin
      sh = sum_r[r] >>> 14;
      if (sh > 50'sd2147483647) begin
        cam_nxt[r] = 32'sh7FFFFFFF;
      end else if (sh < -50'sd2147483648) begin
        cam_nxt[r] = 32'sh80000000;
      end else begin
        cam_nxt[r] = sh[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
      cam_r  <= cam_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  assign out_valid = v_r[2];
  assign cam_x     = cam_r[0];
  assign cam_y     = cam_r[1];
  assign cam_z     = cam_r[2];

endmodule
`default_nettype wire

// File: hdl/lppp_proj.sv
`default_nettype none
module lppp_proj (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] z,
  input  wire logic        [31:0] f,
  input  wire logic        [31:0] c,
  output lppp_pkg::proj_res_t     res
);

  localparam int QB = lppp_pkg::QBITS;
  localparam int NB = lppp_pkg::NBITS;

  logic signed [63:0] prod_r;
  logic [30:0]        zm_r;

  logic [30:0]        rem_r  [QB+1];
  logic [QB-1:0]      word_r [QB+1];
  logic [30:0]        zd_r   [QB+1];
  logic               neg_r  [QB+1];
  logic               ovf_r  [QB+1];

  lppp_pkg::proj_res_t res_r;
  lppp_pkg::proj_res_t res_nxt;

  // Multiply: a is signed, f unsigned.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 64'(a) * $signed({32'd0, f});
      zm_r   <= z[30:0];
    end
  end

  // Prepare magnitude, flag quotients too large for the divider.
  always_ff @(posedge clk) begin
    logic [63:0] mag;
    if (en) begin
      mag       = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
      rem_r[0]  <= {8'd0, mag[62:QB]};
      word_r[0] <= mag[QB-1:0];
      zd_r[0]   <= zm_r;
      neg_r[0]  <= prod_r[63];
      ovf_r[0]  <= {8'd0, mag[62:QB]} >= zm_r;
    end
  end

  // One restoring division step per stage.
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [31:0]   t;
    logic          ge;
    logic [30:0]   rem_nxt;
    logic [QB-1:0] word_nxt;

    always_comb begin
      t        = {rem_r[i], word_r[i][QB-1]};
      ge       = t >= {1'b0, zd_r[i]};
      rem_nxt  = ge ? 31'(t - {1'b0, zd_r[i]}) : t[30:0];
      word_nxt = {word_r[i][QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= rem_nxt;
        word_r[i+1] <= word_nxt;
        zd_r[i+1]   <= zd_r[i];
        neg_r[i+1]  <= neg_r[i];
        ovf_r[i+1]  <= ovf_r[i];
      end
    end
  end

  // Floor quotient for negative products, then add the principal point.
  always_comb begin
    logic signed [NB-1:0] q;
    res_nxt.rnz = rem_r[QB] != 31'd0;
    res_nxt.ok  = !ovf_r[QB];
    if (neg_r[QB]) begin
      q = -$signed(NB'(word_r[QB])) - $signed(NB'(res_nxt.rnz));
    end else begin
      q = $signed(NB'(word_r[QB]));
    end
    res_nxt.n = q + $signed(NB'(c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: hdl/lppp_pixel.sv
`default_nettype none
module lppp_pixel #(
  parameter int PIXEL_COORD_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic                pos,
  input  wire logic signed [31:0]  depth,
  input  wire lppp_pkg::proj_res_t res_x,
  input  wire lppp_pkg::proj_res_t res_y,
  input  wire logic [15:0]         width,
  input  wire logic [15:0]         height,
  output logic                     out_valid,
  output logic                     out_in_view,
  output logic [15:0]              out_col,
  output logic [15:0]              out_row,
  output logic [31:0]              out_index,
  output logic signed [31:0]       out_depth
);

  localparam int NB = lppp_pkg::NBITS;
  localparam int PB = NB - 16;

  typedef struct packed {
    logic          ok;
    logic [PB-1:0] pix;
  } pix_t;

  function automatic pix_t eval_pix(lppp_pkg::proj_res_t r);
    pix_t p;
    if (r.n[NB-1]) begin
      p.pix = '0;
      p.ok  = r.ok && ((r.n > -44'sd65536) || (r.n == -44'sd65536 && r.rnz));
    end else begin
      p.pix = r.n[NB-1:16];
      p.ok  = r.ok;
    end
    return p;
  endfunction

  pix_t               px;
  pix_t               py;
  logic               view_nxt;
  logic [2:0]         v_r;
  logic               view_r;
  logic               view2_r;
  logic [15:0]        col_r;
  logic [15:0]        row_r;
  logic [15:0]        col2_r;
  logic [31:0]        idx_r;
  logic signed [31:0] dep_r;
  logic signed [31:0] dep2_r;
  logic               view3_r;
  logic [15:0]        col3_r;
  logic [15:0]        row3_r;
  logic [31:0]        index3_r;
  logic signed [31:0] dep3_r;
  logic [15:0]        row2_r;

  always_comb begin
    px = eval_pix(res_x);
    py = eval_pix(res_y);
    view_nxt = pos && px.ok && py.ok
            && (px.pix < PB'(width)) && (py.pix < PB'(height))
            && ((px.pix >> PIXEL_COORD_BITS) == '0)
            && ((py.pix >> PIXEL_COORD_BITS) == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      view_r   <= view_nxt;
      col_r    <= view_nxt ? px.pix[15:0] : 16'd0;
      row_r    <= view_nxt ? py.pix[15:0] : 16'd0;
      dep_r    <= depth;
      idx_r    <= 32'(row_r) * 32'(width);
      view2_r  <= view_r;
      col2_r   <= col_r;
      row2_r   <= row_r;
      dep2_r   <= dep_r;
      index3_r <= idx_r + 32'(col2_r);
      view3_r  <= view2_r;
      col3_r   <= col2_r;
      row3_r   <= row2_r;
      dep3_r   <= dep2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  assign out_valid   = v_r[2];
  assign out_in_view = view3_r;
  assign out_col     = col3_r;
  assign out_row     = row3_r;
  assign out_index   = index3_r;
  assign out_depth   = dep3_r;

endmodule
`default_nettype wire

// File: hdl/lidar_point_to_pixel_projection_core.sv
// Throughput: one point per cycle while out_stall holds no result; the 40-step pipelined divider sets the depth.
// All stages advance together; a held result freezes the whole pipeline.
// Reset clears every valid bit and sets all configuration registers to zero.
`default_nettype none
`include "lidar_point_to_pixel_projection_core_macros.svh"
module lidar_point_to_pixel_projection_core #(
  parameter int PIXEL_COORD_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [31:0]                 in_point_x,
  input  wire logic signed [31:0]                 in_point_y,
  input  wire logic signed [31:0]                 in_point_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_in_view,
  output logic [15:0]                             out_pixel_col,
  output logic [15:0]                             out_pixel_row,
  output logic [31:0]                             out_pixel_index,
  output logic signed [31:0]                      out_camera_depth,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lppp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [63:0]                        cfg_data
);

  localparam int PL = lppp_pkg::PROJ_LAT;

  logic [63:0] row0_r, row1_r, row2_r, focal_r, pp_r;
  logic [31:0] dims_r;

  logic               en;
  logic               xv;
  logic signed [31:0] cam_x, cam_y, cam_z;

  logic [PL-1:0]      v_r;
  logic               pos_r [PL];
  logic signed [31:0] dep_r [PL];

  lppp_pkg::proj_res_t res_x, res_y;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r  <= '0;
      row1_r  <= '0;
      row2_r  <= '0;
      focal_r <= '0;
      pp_r    <= '0;
      dims_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (lppp_pkg::cfg_idx_t'(cfg_index))
        lppp_pkg::CFG_ROW0:  row0_r  <= cfg_data;
        lppp_pkg::CFG_ROW1:  row1_r  <= cfg_data;
        lppp_pkg::CFG_ROW2:  row2_r  <= cfg_data;
        lppp_pkg::CFG_FOCAL: focal_r <= cfg_data;
        lppp_pkg::CFG_PP:    pp_r    <= cfg_data;
        lppp_pkg::CFG_DIMS:  dims_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  lppp_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .px        (in_point_x),
    .py        (in_point_y),
    .pz        (in_point_z),
    .row0      (row0_r),
    .row1      (row1_r),
    .row2      (row2_r),
    .out_valid (xv),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z)
  );

  lppp_proj u_proj_col (
    .clk (clk),
    .en  (en),
    .a   (cam_x),
    .z   (cam_z),
    .f   (focal_r[31:0]),
    .c   (pp_r[31:0]),
    .res (res_x)
  );

  lppp_proj u_proj_row (
    .clk (clk),
    .en  (en),
    .a   (cam_y),
    .z   (cam_z),
    .f   (focal_r[63:32]),
    .c   (pp_r[63:32]),
    .res (res_y)
  );

  // Carry depth and its sign alongside the divider.
  always_ff @(posedge clk) begin
    if (en) begin
      pos_r[0] <= cam_z > 32'sd0;
      dep_r[0] <= cam_z;
      for (int i = 1; i < PL; i++) begin
        pos_r[i] <= pos_r[i-1];
        dep_r[i] <= dep_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[PL-2:0], xv};
    end
  end

  lppp_pixel #(
    .PIXEL_COORD_BITS (PIXEL_COORD_BITS)
  ) u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v_r[PL-1]),
    .pos         (pos_r[PL-1]),
    .depth       (dep_r[PL-1]),
    .res_x       (res_x),
    .res_y       (res_y),
    .width       (dims_r[15:0]),
    .height      (dims_r[31:16]),
    .out_valid   (out_valid),
    .out_in_view (out_in_view),
    .out_col     (out_pixel_col),
    .out_row     (out_pixel_row),
    .out_index   (out_pixel_index),
    .out_depth   (out_camera_depth)
  );

  `LPPP_ASSERT_IMP(a_oov_zero, clk, rst_n, out_valid && !out_in_view, out_pixel_index == 32'd0 && out_pixel_col == 16'd0 && out_pixel_row == 16'd0)
  `LPPP_ASSERT_IMP(a_view_depth, clk, rst_n, out_valid && out_in_view, out_camera_depth > 32'sd0)
  `LPPP_ASSERT_IMP(a_row_limit, clk, rst_n, out_valid && out_in_view, (32'(out_pixel_row) >> PIXEL_COORD_BITS) == 32'd0)
  `LPPP_ASSERT_NXT(a_stall_hold, clk, rst_n, in_stall, out_valid)

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic        in_view;
    logic [15:0] col;
    logic [15:0] row;
    logic [31:0] index;
    logic [31:0] depth;
  } pixel_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_in_view;
  logic [15:0] out_pixel_col, out_pixel_row;
  logic [31:0] out_pixel_index;
  logic signed [31:0] out_camera_depth;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [lppp_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [63:0] cfg_data = 0;

  always #2 clk = ~clk;

  lidar_point_to_pixel_projection_core dut (.*);

  logic [63:0] ext_row [3];
  logic [63:0] focal, ppoint;
  logic [31:0] dims;
  pixel_t pixel_q[$];
  int errors = 0;
  int n_points = 0, n_visible = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint cam_coord(logic [63:0] r, longint x, longint y, longint z);
    longint acc, q;
    acc = sext16(r[15:0]) * x + sext16(r[31:16]) * y + sext16(r[47:32]) * z
        + sext16(r[63:48]) * (longint'(1) <<< 20);
    q = (acc + (longint'(1) <<< 13)) >>> 14;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // Returns 0 if the truncated coordinate is negative.
  function automatic bit pix_coord(longint a, logic [31:0] f, logic [31:0] c, longint z,
                                   output longint pix);
    longint prod, q, r, lim, n;
    prod = a * longint'({32'd0, f});
    q = prod / z;
    r = prod % z;
    lim = longint'(1) <<< 40;
    if (r < 0) begin
      q -= 1;
      r += z;
    end
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    n = q + longint'({32'd0, c});
    pix = 0;
    if (n >= 0) begin
      pix = n >>> 16;
      return 1;
    end
    if (n > -65536 || (n == -65536 && r != 0)) return 1;
    return 0;
  endfunction

  function automatic pixel_t project_point(longint x, longint y, longint z);
    pixel_t p;
    longint cxv, cyv, czv, col, row, w, h;
    bit view;
    cxv = cam_coord(ext_row[0], x, y, z);
    cyv = cam_coord(ext_row[1], x, y, z);
    czv = cam_coord(ext_row[2], x, y, z);
    w = dims[15:0];
    h = dims[31:16];
    col = 0;
    row = 0;
    view = 0;
    if (czv > 0 && pix_coord(cxv, focal[31:0], ppoint[31:0], czv, col)
        && pix_coord(cyv, focal[63:32], ppoint[63:32], czv, row))
      view = col < w && row < h && col < 65536 && row < 65536;
    if (!view) begin
      col = 0;
      row = 0;
    end
    p.in_view = view;
    p.col = col[15:0];
    p.row = row[15:0];
    p.index = view ? 32'(row * w + col) : 32'd0;
    p.depth = czv[31:0];
    return p;
  endfunction

  task automatic write_reg(lppp_pkg::cfg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      lppp_pkg::CFG_ROW0: ext_row[0] = val;
      lppp_pkg::CFG_ROW1: ext_row[1] = val;
      lppp_pkg::CFG_ROW2: ext_row[2] = val;
      lppp_pkg::CFG_FOCAL: focal = val;
      lppp_pkg::CFG_PP: ppoint = val;
      lppp_pkg::CFG_DIMS: dims = val[31:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_setup(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] f, logic [63:0] pp, logic [31:0] d);
    drain();
    write_reg(lppp_pkg::CFG_ROW0, r0);
    write_reg(lppp_pkg::CFG_ROW1, r1);
    write_reg(lppp_pkg::CFG_ROW2, r2);
    write_reg(lppp_pkg::CFG_FOCAL, f);
    write_reg(lppp_pkg::CFG_PP, pp);
    write_reg(lppp_pkg::CFG_DIMS, {32'd0, d});
  endtask

  // Hold each request until accepted; the prediction is queued at acceptance.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixel_q.insert(pixel_q.size(), project_point(longint'($signed(x)), longint'($signed(y)),
                                                 longint'($signed(z))));
    n_points++;
  endtask

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      pixel_t e;
      if (pixel_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_in_view) n_visible++;
        if (out_in_view !== e.in_view) begin
          $error("in_view exp %0d got %0d", e.in_view, out_in_view); errors++;
        end
        if (out_pixel_col !== e.col) begin
          $error("pixel_col exp %0d got %0d", e.col, out_pixel_col); errors++;
        end
        if (out_pixel_row !== e.row) begin
          $error("pixel_row exp %0d got %0d", e.row, out_pixel_row); errors++;
        end
        if (out_pixel_index !== e.index) begin
          $error("pixel_index exp %0d got %0d", e.index, out_pixel_index); errors++;
        end
        if (out_camera_depth !== e.depth) begin
          $error("camera_depth exp %0h got %0h", e.depth, out_camera_depth); errors++;
        end
      end
    end
  end

  typedef struct {
    logic [31:0] x, y, z;
    bit          check;
    pixel_t      want;
  } point_row_t;

  localparam logic [63:0] IDENT0 = {16'h0000, 16'h0000, 16'h0000, 16'h4000};
  localparam logic [63:0] IDENT1 = {16'h0000, 16'h0000, 16'h4000, 16'h0000};
  localparam logic [63:0] IDENT2 = {16'h0000, 16'h4000, 16'h0000, 16'h0000};
  localparam logic [63:0] FOCAL_STD = {32'd500 << 16, 32'd500 << 16};
  localparam logic [63:0] PP_STD = {32'd240 << 16, 32'd320 << 16};
  localparam logic [31:0] DIMS_STD = {16'd480, 16'd640};

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(7))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
      default: return $urandom_range(100 << 16, 1 << 14);
    endcase
  endfunction

  function automatic logic [63:0] rand_rot_row(int axis);
    logic [15:0] c [3];
    for (int i = 0; i < 3; i++)
      c[i] = (i == axis) ? 16'(16'h4000 - $urandom_range(800))
                         : 16'($signed($urandom_range(1600)) - 800);
    return {16'($urandom), c[2], c[1], c[0]};
  endfunction

  point_row_t dir_rows[$];
  pixel_t zero_pix, p;

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit chk,
                         pixel_t want);
    point_row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.check = chk;
    r.want = want;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    ext_row = '{0, 0, 0};
    focal = 0;
    ppoint = 0;
    dims = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Reset state: everything zero, depth zero, never in view.
    zero_pix = '{0, 0, 0, 0, 0};
    add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, zero_pix);
    add_row(0, 0, 0, 1, zero_pix);
    foreach (dir_rows[i]) begin
      p = project_point(longint'($signed(dir_rows[i].x)), longint'($signed(dir_rows[i].y)),
                        longint'($signed(dir_rows[i].z)));
      if (p != dir_rows[i].want) begin
        $error("reset-state prediction disagrees on row %0d", i); errors++;
      end
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
    end
    in_valid <= 0;

    // Identity camera, VGA: on-axis, behind, zero depth, fractional, saturating.
    load_setup(IDENT0, IDENT1, IDENT2, FOCAL_STD, PP_STD, DIMS_STD);
    dir_rows.delete();
    add_row(0, 0, 32'd10 << 16, 0, zero_pix);
    add_row(0, 0, -(32'd10 << 16), 1, '{0, 0, 0, 0, -(32'd10 << 16)});
    add_row(32'd1 << 16, 0, 0, 1, zero_pix);
    add_row(-(32'd64 << 16), 0, 32'd10 << 16, 0, zero_pix);
    add_row(-(32'd65 << 16), 0, 32'd10 << 16, 0, zero_pix);
    add_row(32'h80000000, 32'h7fffffff, 32'd1, 0, zero_pix);
    add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, zero_pix);
    add_row(32'h80000000, 32'h80000000, 32'h80000000, 0, zero_pix);
    add_row(32'd64 << 16, 32'd48 << 16, 32'd10 << 16, 0, zero_pix);
    add_row(32'hffffffff, 32'hffffffff, 32'd1 << 16, 0, zero_pix);
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      if (dir_rows[i].check && pixel_q[$] != dir_rows[i].want) begin
        $error("directed row %0d prediction mismatch", i); errors++;
      end
    end
    in_valid <= 0;

    // Extreme registers: all ones, then zero-size image.
    load_setup('1, '1, '1, '1, '1, '1);
    for (int i = 0; i < 4; i++) send_point($urandom, $urandom, $urandom);
    in_valid <= 0;
    load_setup(IDENT0, IDENT1, IDENT2, FOCAL_STD, PP_STD, 32'h01e0_0000);
    for (int i = 0; i < 3; i++) send_point(0, 0, 32'd5 << 16);
    in_valid <= 0;

    // Random phases with varying idle/stall and calibration.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      in_valid <= 0;
      if (ph == 7)
        load_setup($urandom_range(1) ? {$urandom, $urandom} : '1, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom);
      else
        load_setup(rand_rot_row(0), rand_rot_row(1), rand_rot_row(2),
                   {32'($urandom_range(1200, 100)) << 16, 32'($urandom_range(1200, 100)) << 16}
                   | {$urandom_range(65535), $urandom_range(65535)} ,
                   {32'($urandom_range(600)) << 16 | $urandom_range(65535),
                    32'($urandom_range(900)) << 16 | $urandom_range(65535)},
                   {16'($urandom_range(1080, 1)), 16'($urandom_range(1920, 1))});
      for (int i = 0; i < 130; i++) begin
        if (ph == 3 && i == 60) begin
          // Hold off until the pipeline is empty.
          in_valid <= 0;
          while (pixel_q.size() != 0) @(posedge clk);
        end
        send_point(rand_coord(), rand_coord(), rand_depth());
      end
    end
    in_valid <= 0;
    recv_stall_pct = 0;
    drain();
    $display("Projected %0d points over 11 calibrations, %0d landed inside the image.",
             n_points, n_visible);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
